>>> src/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types and constants of the vertex skinning engine.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam int WordsPerBone = 12;
  localparam logic [16:0] OneWeight = 17'd65536;

  typedef enum logic [1:0] {
    OP_MATRIX  = 2'd0,
    OP_PRIMARY = 2'd1,
    OP_ADDITIVE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_WRITE,
    K_PRIMARY,
    K_ADDITIVE
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [5:0]              bone;
    logic [3:0]              elem;
    logic [2:0][31:0]        pos;
    logic [2:0][15:0]        norm;
    logic [16:0]             weight;
    logic [2:0]              count;
    logic                    surf_end;
  } item_t;

  typedef struct packed {
    logic [15:0]             vertex_index;
    logic [2:0][31:0]        pos;
    logic [2:0][15:0]        norm;
    logic                    last;
  } result_t;

endpackage

>>> src/lbvs_front.sv
// ----------------------------------------------------------------------------
// lbvs_front
// Accepts input items, classifies them, drops those with no effect and
// holds the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lbvs_front import lbvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  bone_index_i,
  input  logic [3:0]  element_index_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [15:0] norm_x_i,
  input  logic [15:0] norm_y_i,
  input  logic [15:0] norm_z_i,
  input  logic [16:0] weight_i,
  input  logic [2:0]  additive_count_i,
  input  logic        surface_end_i,
  output logic        head_valid_o,
  output item_t       head_o,
  input  logic        head_pop_i
);

  item_t       fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       item;
  logic        keep, do_push;

  always_comb begin
    item.bone     = bone_index_i;
    item.elem     = element_index_i;
    item.pos      = {pos_z_i, pos_y_i, pos_x_i};
    item.norm     = {norm_z_i, norm_y_i, norm_x_i};
    item.weight   = (weight_i > OneWeight) ? OneWeight : weight_i;
    item.count    = additive_count_i;
    item.surf_end = surface_end_i;
    keep          = 1'b1;
    unique case (op_e'(operation_i))
      OP_MATRIX: begin
        item.kind = K_WRITE;
        keep      = (int'(element_index_i) < WordsPerBone);
      end
      OP_PRIMARY:  item.kind = K_PRIMARY;
      OP_ADDITIVE: item.kind = K_ADDITIVE;
      default: begin
        item.kind = K_WRITE;
        keep      = 1'b0;
      end
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];
  // drop items with no effect at the door
  assign do_push      = push && !full && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
      cnt_d    = cnt_d + 2'd1;
    end
    if (head_pop_i && head_valid_o) begin
      rd_ptr_d = ~rd_ptr_q;
      cnt_d    = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wr_ptr_q] <= item;
  end

endmodule

>>> src/lbvs_back.sv
// ----------------------------------------------------------------------------
// lbvs_back
// Bone matrix store and skinning sequencer: one matrix word per step,
// one product per step, results into a single output register.
// ----------------------------------------------------------------------------
module lbvs_back import lbvs_pkg::*; #(
  parameter int BONES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        head_valid_i,
  input  item_t       head_i,
  output logic        head_pop_o,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        res_pop_i
);

  localparam int Words = BONES * WordsPerBone;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_WMUL, S_WACC, S_DONE
  } state_e;

  logic [31:0]        mem [Words];
  logic [31:0]        rdata_q;
  logic               mem_we;
  logic [AW-1:0]      waddr, raddr;

  state_e             state_q;
  item_t              cur_q;
  logic [1:0]         c_q, k_q;
  logic signed [63:0] prod_p_q;
  logic signed [47:0] prod_n_q;
  logic signed [49:0] sum_p_q;
  logic signed [33:0] sum_n_q;
  logic signed [49:0] wprod_q;
  logic [2:0][47:0]   acc_q;
  logic [2:0][31:0]   t_q;
  logic [2:0][15:0]   held_q;
  logic [2:0]         points_q;
  logic               pend_end_q;
  logic [15:0]        counter_q, base_q;
  logic               res_valid_q;
  result_t            res_q;

  logic               bone_ok, head_bone_ok;
  logic [3:0]         elem;
  logic signed [31:0] word;
  logic [1:0]         pidx;
  logic signed [31:0] t_sat;
  logic               is_prim, emit, can_emit;

  function automatic logic [31:0] sat32(logic signed [49:0] v);
    if (v > 50'sd2147483647)       return 32'h7fff_ffff;
    else if (v < -50'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

  function automatic logic [15:0] sat16(logic signed [33:0] v);
    if (v > 34'sd32767)       return 16'h7fff;
    else if (v < -34'sd32768) return 16'h8000;
    else                      return v[15:0];
  endfunction

  assign bone_ok      = (int'(cur_q.bone) < BONES);
  assign head_bone_ok = (int'(head_i.bone) < BONES);
  assign elem         = (k_q == 2'd3) ? (4'd9 + {2'b0, c_q})
                                      : ({2'b0, k_q} * 4'd3 + {2'b0, c_q});
  assign raddr        = AW'(int'(cur_q.bone) * WordsPerBone + int'(elem));
  assign waddr        = AW'(int'(head_i.bone) * WordsPerBone + int'(head_i.elem));
  assign word         = bone_ok ? $signed(rdata_q) : 32'sd0;
  assign pidx         = (k_q == 2'd3) ? 2'd0 : k_q;
  assign t_sat        = $signed(sat32(sum_p_q));
  assign is_prim      = (cur_q.kind == K_PRIMARY);
  assign emit         = is_prim ? (cur_q.count == 3'd0) : (points_q == 3'd1);
  assign can_emit     = !res_valid_q || res_pop_i;

  assign mem_we     = (state_q == S_IDLE) && head_valid_i &&
                      (head_i.kind == K_WRITE) && head_bone_ok;
  assign head_pop_o = (state_q == S_IDLE) && head_valid_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= head_i.pos[0];
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      c_q         <= 2'd0;
      k_q         <= 2'd0;
      acc_q       <= '0;
      held_q      <= '0;
      points_q    <= 3'd0;
      pend_end_q  <= 1'b0;
      counter_q   <= 16'd0;
      base_q      <= 16'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (res_pop_i && res_valid_q) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            cur_q <= head_i;
            c_q   <= 2'd0;
            k_q   <= 2'd0;
            sum_p_q <= '0;
            sum_n_q <= '0;
            // an additive point with nothing pending is dropped here
            if (head_i.kind == K_PRIMARY ||
                (head_i.kind == K_ADDITIVE && points_q != 3'd0)) begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          prod_p_q <= $signed(cur_q.pos[pidx]) * word;
          prod_n_q <= $signed(cur_q.norm[pidx]) * word;
          state_q  <= S_ACC;
        end
        S_ACC: begin
          if (k_q == 2'd3) begin
            sum_p_q <= sum_p_q + 50'(word);
            state_q <= S_WMUL;
          end else begin
            sum_p_q <= sum_p_q + 50'($signed(prod_p_q[63:16]));
            sum_n_q <= sum_n_q + 34'($signed(prod_n_q[47:16]));
            k_q     <= k_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_WMUL: begin
          wprod_q <= t_sat * $signed({1'b0, cur_q.weight});
          t_q[c_q] <= t_sat;
          if (is_prim) held_q[c_q] <= sat16(sum_n_q);
          state_q <= S_WACC;
        end
        S_WACC: begin
          if (is_prim) acc_q[c_q] <= 48'($signed(wprod_q[49:16]));
          else         acc_q[c_q] <= acc_q[c_q] + 48'($signed(wprod_q[49:16]));
          sum_p_q <= '0;
          sum_n_q <= '0;
          k_q     <= 2'd0;
          if (c_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            c_q     <= c_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (!emit || can_emit) begin
            if (is_prim) begin
              points_q   <= cur_q.count;
              pend_end_q <= cur_q.surf_end;
            end else begin
              points_q <= points_q - 3'd1;
            end
            if (emit) begin
              res_valid_q        <= 1'b1;
              res_q.vertex_index <= base_q + counter_q;
              res_q.norm         <= held_q;
              counter_q          <= counter_q + 16'd1;
              if (is_prim) begin
                res_q.pos  <= t_q;
                res_q.last <= cur_q.surf_end;
              end else begin
                res_q.pos[0] <= sat32(50'($signed(acc_q[0])));
                res_q.pos[1] <= sat32(50'($signed(acc_q[1])));
                res_q.pos[2] <= sat32(50'($signed(acc_q[2])));
                res_q.last   <= pend_end_q;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Vertex skinning engine: bone matrix store, weighted position blend and
// normal rotation, queue handshakes on both sides.
// ----------------------------------------------------------------------------
// The back end takes a matrix word write in its idle state. A primary vertex
// or an additive point runs three components, each four matrix words read
// one per step through the single memory read port (read, multiply, add),
// then a weight multiply and an accumulate; a closing step holds while a
// vertex to emit finds the result register full. A two-entry input queue
// lets new items in while one is worked on, and a one-entry result register
// holds the finished vertex until popped. The matrix store has no reset.
module linear_blend_vertex_skinning import lbvs_pkg::*; #(
  parameter int BONES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  bone_index_i,
  input  logic [3:0]  element_index_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [15:0] norm_x_i,
  input  logic [15:0] norm_y_i,
  input  logic [15:0] norm_z_i,
  input  logic [16:0] weight_i,
  input  logic [2:0]  additive_count_i,
  input  logic        surface_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] vertex_index_o,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic [15:0] out_norm_x_o,
  output logic [15:0] out_norm_y_o,
  output logic [15:0] out_norm_z_o,
  output logic        last_of_surface_o
);

  logic    head_valid, head_pop, res_valid;
  item_t   head;
  result_t res;

  lbvs_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .operation_i, .bone_index_i, .element_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .norm_x_i, .norm_y_i, .norm_z_i,
    .weight_i, .additive_count_i, .surface_end_i,
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  lbvs_back #(.BONES(BONES)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty             = !res_valid;
  assign vertex_index_o    = res.vertex_index;
  assign out_pos_x_o       = res.pos[0];
  assign out_pos_y_o       = res.pos[1];
  assign out_pos_z_o       = res.pos[2];
  assign out_norm_x_o      = res.norm[0];
  assign out_norm_y_o      = res.norm[1];
  assign out_norm_z_o      = res.norm[2];
  assign last_of_surface_o = res.last;

endmodule

>>> tb/sv/tb_linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// tb_linear_blend_vertex_skinning
// Self-checking bench for the skinning engine: loads a few bone matrices,
// sends directed and random vertex streams under varied back-pressure, and
// compares every popped vertex with a cycle-free model of the engine.
// ----------------------------------------------------------------------------
module tb_linear_blend_vertex_skinning;
  import lbvs_pkg::*;

  localparam int NumBones   = 64;
  localparam int CycleLimit = 1000000;
  localparam int SettleCyc  = 200;

  typedef struct {
    op_e                op;
    logic [5:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [16:0]        weight;
    logic [2:0]         count;
    logic               surf_end;
  } vtx_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        push, full, empty, pop;
  logic [1:0]  operation;
  logic [5:0]  bone_index;
  logic [3:0]  element_index;
  logic [31:0] pos_x, pos_y, pos_z;
  logic [15:0] norm_x, norm_y, norm_z;
  logic [16:0] weight;
  logic [2:0]  additive_count;
  logic        surface_end;
  logic [15:0] vertex_index;
  logic [31:0] o_pos_x, o_pos_y, o_pos_z;
  logic [15:0] o_norm_x, o_norm_y, o_norm_z;
  logic        last_of_surface;

  // Skinning model state
  int      bone_words [NumBones*WordsPerBone];
  longint  blend_acc [3];
  logic [15:0] rotated_normal [3];
  int      points_left;
  logic [15:0] slot_count;
  logic [15:0] slot_base;
  logic    held_end;

  result_t skinned_q [$];
  int      error_count;
  int      cycle_count;
  int      idle_pct, stall_pct;
  int      loaded_bones [4] = '{0, 21, 42, 63};

  always #5 clk = ~clk;

  linear_blend_vertex_skinning #(.BONES(NumBones)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .push(push), .full(full),
    .operation_i(operation), .bone_index_i(bone_index),
    .element_index_i(element_index),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .norm_x_i(norm_x), .norm_y_i(norm_y), .norm_z_i(norm_z),
    .weight_i(weight), .additive_count_i(additive_count),
    .surface_end_i(surface_end),
    .empty(empty), .pop(pop),
    .vertex_index_o(vertex_index),
    .out_pos_x_o(o_pos_x), .out_pos_y_o(o_pos_y), .out_pos_z_o(o_pos_z),
    .out_norm_x_o(o_norm_x), .out_norm_y_o(o_norm_y), .out_norm_z_o(o_norm_z),
    .last_of_surface_o(last_of_surface)
  );

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint axis_word(int bone, int e);
    return longint'(bone_words[bone*WordsPerBone + e]);
  endfunction

  function automatic longint bone_xform(int bone, longint p [3], int c);
    longint s;
    s = axis_word(bone, 9 + c);
    for (int r = 0; r < 3; r++) s += (p[r] * axis_word(bone, r*3 + c)) >>> 16;
    return clamp(s, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void emit_vertex(output result_t r, input longint v [3],
                                      input logic last);
    r.vertex_index = slot_base + slot_count;
    for (int c = 0; c < 3; c++) begin
      r.pos[c]  = 32'(clamp(v[c], -64'sd2147483648, 64'sd2147483647));
      r.norm[c] = rotated_normal[c];
    end
    r.last = last;
    slot_count++;
  endfunction

  // Advance the model by one accepted item; returns 1 when a vertex comes out.
  function automatic bit skin_step(input vtx_item_t it, output result_t r);
    longint p [3], n [3], t [3], w, s;
    p = '{it.px, it.py, it.pz};
    n = '{it.nx, it.ny, it.nz};
    w = it.weight > OneWeight ? longint'(OneWeight) : longint'(it.weight);
    r = '0;
    case (it.op)
      OP_MATRIX: begin
        if (it.elem < WordsPerBone) bone_words[it.bone*WordsPerBone + it.elem] = it.px;
        return 0;
      end
      OP_PRIMARY: begin
        for (int c = 0; c < 3; c++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s += (n[k] * axis_word(it.bone, k*3 + c)) >>> 16;
          rotated_normal[c] = 16'(clamp(s, -32768, 32767));
          t[c] = bone_xform(it.bone, p, c);
        end
        if (it.count == 0) begin
          points_left = 0;
          emit_vertex(r, t, it.surf_end);
          return 1;
        end
        for (int c = 0; c < 3; c++) blend_acc[c] = (t[c] * w) >>> 16;
        points_left = it.count;
        held_end = it.surf_end;
        return 0;
      end
      OP_ADDITIVE: begin
        if (points_left == 0) return 0;
        for (int c = 0; c < 3; c++) blend_acc[c] += (bone_xform(it.bone, p, c) * w) >>> 16;
        points_left--;
        if (points_left == 0) begin
          emit_vertex(r, blend_acc, held_end);
          return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // Transfer one item, with a random gap before it as the phase asks.
  task automatic send_item(vtx_item_t it);
    result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push           <= 1'b1;
    operation      <= it.op;
    bone_index     <= it.bone;
    element_index  <= it.elem;
    pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
    norm_x <= it.nx; norm_y <= it.ny; norm_z <= it.nz;
    weight         <= it.weight;
    additive_count <= it.count;
    surface_end    <= it.surf_end;
    @(posedge clk);
    while (full) @(posedge clk);
    if (skin_step(it, r)) skinned_q.push_back(r);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (skinned_q.size() > 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic set_vertex_base(logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    slot_base = v;
    cfg_we <= 1'b0;
  endtask

  function automatic int rnd_axis();
    if ($urandom_range(4) == 0) return int'($urandom);
    return int'($urandom_range(262143)) - 131072;
  endfunction

  function automatic int rnd_pos();
    if ($urandom_range(3) == 0) return int'($urandom);
    return int'($urandom_range(134217727)) - 67108864;
  endfunction

  function automatic vtx_item_t rnd_item(op_e op);
    vtx_item_t it;
    it.op = op;
    it.bone = 6'(loaded_bones[$urandom_range(3)]);
    it.elem = 4'($urandom_range(11));
    it.px = rnd_pos(); it.py = rnd_pos(); it.pz = rnd_pos();
    it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
    it.weight = $urandom_range(9) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
    it.count = 3'($urandom);
    it.surf_end = 1'($urandom);
    return it;
  endfunction

  task automatic test_load_bones();
    vtx_item_t it;
    foreach (loaded_bones[b]) begin
      for (int e = 0; e < WordsPerBone; e++) begin
        it = rnd_item(OP_MATRIX);
        it.bone = 6'(loaded_bones[b]);
        it.elem = 4'(e);
        if (b == 0) it.px = (e == 0 || e == 4 || e == 8) ? 32'sh0001_0000 : 32'sd0;
        else if (b == 3 && e < 9) it.px = e[0] ? 32'h8000_0000 : 32'h7fff_ffff;
        else it.px = rnd_axis();
        send_item(it);
      end
    end
    // word indexes past the origin must be dropped
    for (int e = WordsPerBone; e < 16; e++) begin
      it = rnd_item(OP_MATRIX);
      it.elem = 4'(e);
      it.bone = 6'(loaded_bones[$urandom_range(1)]);
      send_item(it);
    end
  endtask

  task automatic test_directed();
    vtx_item_t it;
    // lone primaries at the field extremes, both surface flags
    it = rnd_item(OP_PRIMARY); it.bone = 6'd63; it.count = 0;
    it.px = 32'h7fff_ffff; it.py = 32'h8000_0000; it.pz = 0;
    it.nx = 16'h8000; it.ny = 16'h7fff; it.nz = 16'h8000; it.surf_end = 1;
    send_item(it);
    it = rnd_item(OP_PRIMARY); it.bone = 6'd0; it.count = 0;
    it.px = 32'h8000_0000; it.py = 32'h7fff_ffff; it.pz = 32'hffff_ffff;
    it.nx = 16'h7fff; it.ny = 0; it.nz = 16'hffff; it.surf_end = 0;
    send_item(it);
    // blend with zero, full and over-range weights
    it = rnd_item(OP_PRIMARY); it.count = 3; it.weight = 0; send_item(it);
    it = rnd_item(OP_ADDITIVE); it.weight = OneWeight; send_item(it);
    // rewrite a matrix word mid-vertex; the next point sees it
    it = rnd_item(OP_MATRIX); it.bone = 6'd21; it.elem = 4'd10; send_item(it);
    it = rnd_item(OP_ADDITIVE); it.bone = 6'd21; it.weight = 17'h1ffff; send_item(it);
    it = rnd_item(OP_ADDITIVE); it.bone = 6'd63; it.weight = 17'd65537; send_item(it);
    // stray additive, unused operation
    it = rnd_item(OP_ADDITIVE); send_item(it);
    it = rnd_item(OP_UNUSED); send_item(it);
    // a primary cut short by another primary is dropped
    it = rnd_item(OP_PRIMARY); it.count = 7; send_item(it);
    it = rnd_item(OP_ADDITIVE); send_item(it);
    it = rnd_item(OP_PRIMARY); it.count = 1; it.weight = OneWeight; send_item(it);
    it = rnd_item(OP_ADDITIVE); it.weight = 17'h1ffff; send_item(it);
  endtask

  task automatic test_random_stream(int n_items, int idle, int stall, bit pause_mid);
    vtx_item_t it;
    int sent;
    int n_pts;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if (pause_mid && sent >= n_items / 2) begin
        drain();
        pause_mid = 0;
      end
      if ($urandom_range(9) < 7) begin
        it = rnd_item(OP_PRIMARY);
        n_pts = it.count;
        if ($urandom_range(7) == 0 && n_pts > 0) n_pts = $urandom_range(n_pts - 1);
        send_item(it);
        sent++;
        for (int k = 0; k < n_pts; k++) begin
          if ($urandom_range(15) == 0) send_item(rnd_item(OP_MATRIX));
          send_item(rnd_item(OP_ADDITIVE));
          sent++;
        end
      end else begin
        case ($urandom_range(3))
          0: begin
            it = rnd_item(OP_MATRIX);
            if ($urandom_range(1)) it.elem = 4'($urandom_range(12, 15));
            send_item(it);
            sent++;
          end
          1: send_item(rnd_item(OP_ADDITIVE));
          2: send_item(rnd_item(OP_UNUSED));
          default: begin
            it = rnd_item(OP_MATRIX);
            it.px = rnd_axis();
            send_item(it);
            sent++;
          end
        endcase
      end
    end
  endtask

  // Check each popped vertex against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (skinned_q.size() == 0) begin
        error_count++;
        $display("unexpected vertex at slot %0d", vertex_index);
      end else begin
        result_t want;
        want = skinned_q.pop_front();
        if (vertex_index !== want.vertex_index)
          report_mismatch("vertex_index", vertex_index, want.vertex_index);
        if (o_pos_x !== want.pos[0]) report_mismatch("out_pos_x", o_pos_x, want.pos[0]);
        if (o_pos_y !== want.pos[1]) report_mismatch("out_pos_y", o_pos_y, want.pos[1]);
        if (o_pos_z !== want.pos[2]) report_mismatch("out_pos_z", o_pos_z, want.pos[2]);
        if (o_norm_x !== want.norm[0]) report_mismatch("out_norm_x", o_norm_x, want.norm[0]);
        if (o_norm_y !== want.norm[1]) report_mismatch("out_norm_y", o_norm_y, want.norm[1]);
        if (o_norm_z !== want.norm[2]) report_mismatch("out_norm_z", o_norm_z, want.norm[2]);
        if (last_of_surface !== want.last)
          report_mismatch("last_of_surface", last_of_surface, want.last);
      end
    end
  end

  always @(posedge clk) begin
    pop <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    error_count = 0; cycle_count = 0;
    idle_pct = 0; stall_pct = 0;
    blend_acc = '{0, 0, 0};
    rotated_normal = '{0, 0, 0};
    points_left = 0; slot_count = 0; slot_base = 0; held_end = 0;
    foreach (bone_words[i]) bone_words[i] = 0;
    rst_n <= 1'b0; cfg_we <= 1'b0; cfg_wdata <= '0; push <= 1'b0; pop <= 1'b0;
    operation <= '0; bone_index <= '0; element_index <= '0;
    pos_x <= '0; pos_y <= '0; pos_z <= '0;
    norm_x <= '0; norm_y <= '0; norm_z <= '0;
    weight <= '0; additive_count <= '0; surface_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_bones();
    test_directed();
    set_vertex_base(16'hffff);
    test_random_stream(100, 0, 0, 0);
    set_vertex_base(16'($urandom));
    test_random_stream(100, 64, 0, 1);
    set_vertex_base(16'h0000);
    test_random_stream(100, 0, 64, 0);
    set_vertex_base(16'($urandom));
    test_random_stream(100, 12, 12, 0);
    drain();

    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
src/lbvs_pkg.sv
src/lbvs_front.sv
src/lbvs_back.sv
src/linear_blend_vertex_skinning.sv
tb/sv/tb_linear_blend_vertex_skinning.sv
